// File: sv/dmsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsd_pkg: shared definitions for the dual-mode sync deframer
// Widths, the configuration bundle and the CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package dmsd_pkg;

   // Width of the sync history and of the compared part of each sync word.
   localparam int SYNC_BITS = 64;
   // Width of the byte position counter inside a frame.
   localparam int INDEX_BITS = 16;
   // A total is a 16-bit length plus two, so it needs 17 bits.
   localparam int TOTAL_BITS = 17;

   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef struct packed {
      logic [63:0] sync_word_mode1;
      logic [63:0] sync_word_mode2;
      logic [7:0]  key_mode1;
      logic [7:0]  key_mode2;
      logic [15:0] max_frame;
   } cfg_type;

   // Reflected CRC-16 update with one byte, least significant bit first.
   function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
      logic [15:0] crc;
      logic        fb;
      crc = crc_in;
      for (int j = 0; j < 8; j++) begin
         fb  = crc[0] ^ data[j];
         crc = {1'b0, crc[15:1]};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// File: sv/dual_mode_sync_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_mode_sync_deframer: sync word search, descrambling and CRC check
// Finds one of two sync words in a bit stream, then assembles bytes in
// Manchester (mode 1) or NRZ (mode 2) form and checks a CRC-16/X.25 trailer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// req_*     in         tdata[0] bit_value, tuser kind (1 = abort frame)
// rsp_*     out        tdata[7:0] data_byte, tdata[23:8] byte_index,
//                      tuser[0] frame_mode, tuser[1] crc_ok,
//                      tuser[2] frame_error, tlast last
// csr_*     in/out     APB-style register port, 64-bit data, 8-byte stride
//
// One word is taken every cycle unless a stall on rsp_tready backs up into
// the input register. A word first lands in the input register; when that
// register drains, a single pass of logic updates the frame state and loads
// the result register.
// The input register drains whenever the result register is empty or being
// taken, so a stall on rsp_tready holds at most two words inside, one result
// and one waiting input word, before req_tready drops.
// Reset is synchronous and returns the block to sync search with the
// registers at their documented defaults.
//
module dual_mode_sync_deframer
   import dmsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // bit stream in
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [0] bit_value, rest zero
   input  wire logic                     req_tuser,   // [0] kind
   // frame bytes out
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [23:0]              rsp_tdata,   // [7:0] data_byte, [23:8] byte_index
   output logic      [2:0]               rsp_tuser,   // [0] frame_mode, [1] crc_ok,
                                                      // [2] frame_error
   output logic                          rsp_tlast,
   // configuration
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   // Frame phase codes.
   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   localparam logic [TOTAL_BITS-1:0] INDEX_LIMIT = TOTAL_BITS'(1) << INDEX_BITS;
   localparam logic [TOTAL_BITS-1:0] MIN_TOTAL_MODE2 = TOTAL_BITS'(3);

   cfg_type cfg;

   dmsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Input register.
   logic in_valid_ff, in_valid_in;
   logic in_kind_ff, in_kind_in;
   logic in_bit_ff, in_bit_in;
   logic advance;

   // Frame state.
   logic [SYNC_BITS-1:0]  history_ff, history_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  mode_ff, mode_in;
   logic [2:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shift_ff, shift_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [7:0]            length_high_ff, length_high_in;
   logic                  take_ff, take_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            trailer_ff, trailer_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_data_ff, out_data_in;
   logic [INDEX_BITS-1:0] out_index_ff, out_index_in;
   logic                  out_mode_ff, out_mode_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ok_ff, out_ok_in;
   logic                  out_err_ff, out_err_in;

   // Step results.
   logic                  emit;
   logic [7:0]            e_data;
   logic                  e_last, e_ok, e_err;
   logic [INDEX_BITS-1:0] e_index;
   logic [SYNC_BITS-1:0]  hist_next;
   logic                  match1, match2;
   logic [7:0]            assembled;
   logic [7:0]            desc_byte;
   logic [TOTAL_BITS-1:0] length_total;
   logic [TOTAL_BITS-1:0] tot;
   logic [TOTAL_BITS-1:0] idx_ext;
   logic                  bad_length;

   // The input register empties when the result register has room.
   assign advance     = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_bit_in   = in_bit_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid & req_tready) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser;
         in_bit_in   = req_tdata[0];
      end
   end

   // Shared datapath terms.
   assign hist_next = {history_ff[SYNC_BITS-2:0], in_bit_ff};
   assign match1    = hist_next == cfg.sync_word_mode1[SYNC_BITS-1:0];
   assign match2    = hist_next == cfg.sync_word_mode2[SYNC_BITS-1:0];
   assign assembled = {shift_ff[6:0], in_bit_ff};
   assign desc_byte = assembled ^ (mode_ff ? cfg.key_mode2 : cfg.key_mode1);
   assign idx_ext   = TOTAL_BITS'(index_ff);

   // Mode 2 carries a big-endian 16-bit length, mode 1 a single byte.
   assign length_total = mode_ff ? (TOTAL_BITS'({length_high_ff, desc_byte}) + TOTAL_BITS'(2))
                                 : (TOTAL_BITS'(desc_byte) + TOTAL_BITS'(2));
   assign bad_length   = (length_total > TOTAL_BITS'(cfg.max_frame)) ||
                         (length_total > INDEX_LIMIT) ||
                         (mode_ff && (length_total < MIN_TOTAL_MODE2));
   assign tot          = (phase_ff == PH_LENGTH) ? length_total : total_ff;

   // One bit, or one abort, per pass.
   always_comb begin
      history_in     = history_ff;
      phase_in       = phase_ff;
      mode_in        = mode_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      index_in       = index_ff;
      total_in       = total_ff;
      length_high_in = length_high_ff;
      take_in        = take_ff;
      crc_in         = crc_ff;
      trailer_in     = trailer_ff;
      emit           = 1'b0;
      e_data         = 8'd0;
      e_index        = index_ff;
      e_last         = 1'b0;
      e_ok           = 1'b0;
      e_err          = 1'b0;

      if (in_kind_ff) begin
         // An abort only matters inside a frame.
         if (phase_ff != PH_SEARCH) begin
            emit     = 1'b1;
            e_last   = 1'b1;
            e_err    = 1'b1;
            phase_in = PH_SEARCH;
         end
      end else if (phase_ff == PH_SEARCH) begin
         history_in = hist_next;
         if (match1 || match2) begin
            // Mode 1 wins when both words match.
            mode_in        = ~match1;
            phase_in       = PH_LENGTH;
            bit_count_in   = 3'd0;
            shift_in       = 8'd0;
            index_in       = '0;
            total_in       = '0;
            length_high_in = 8'd0;
            take_in        = 1'b1;
            crc_in         = CRC_INIT;
            trailer_in     = 8'd0;
         end
      end else begin
         take_in = ~take_ff;
         // Manchester uses only the first bit of each pair.
         if (take_ff || mode_ff) begin
            if (bit_count_ff != 3'd7) begin
               bit_count_in = bit_count_ff + 3'd1;
               shift_in     = assembled;
            end else begin
               bit_count_in = 3'd0;
               shift_in     = 8'd0;
               emit         = 1'b1;
               e_data       = desc_byte;
               if (phase_ff == PH_LENGTH && mode_ff && index_ff == '0) begin
                  length_high_in = desc_byte;
                  crc_in         = crc16_x25_byte(crc_ff, desc_byte);
                  index_in       = index_ff + INDEX_BITS'(1);
               end else if (phase_ff == PH_LENGTH && bad_length) begin
                  total_in = length_total;
                  e_last   = 1'b1;
                  e_err    = 1'b1;
                  phase_in = PH_SEARCH;
               end else begin
                  total_in = tot;
                  phase_in = PH_BODY;
                  if (idx_ext + TOTAL_BITS'(2) < tot) begin
                     crc_in = crc16_x25_byte(crc_ff, desc_byte);
                  end else if (idx_ext + TOTAL_BITS'(2) == tot) begin
                     trailer_in = desc_byte;
                  end
                  if (idx_ext + TOTAL_BITS'(1) >= tot) begin
                     // Final byte: the trailer is little-endian.
                     e_last   = 1'b1;
                     e_ok     = (crc_ff ^ 16'hFFFF) == {desc_byte, trailer_ff};
                     phase_in = PH_SEARCH;
                  end else begin
                     index_in = index_ff + INDEX_BITS'(1);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_index_in = out_index_ff;
      out_mode_in  = out_mode_ff;
      out_last_in  = out_last_ff;
      out_ok_in    = out_ok_ff;
      out_err_in   = out_err_ff;
      if (advance) begin
         out_valid_in = emit;
         out_data_in  = e_data;
         out_index_in = e_index;
         out_mode_in  = mode_ff;
         out_last_in  = e_last;
         out_ok_in    = e_ok;
         out_err_in   = e_err;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         history_ff     <= '0;
         phase_ff       <= PH_SEARCH;
         mode_ff        <= 1'b0;
         bit_count_ff   <= 3'd0;
         shift_ff       <= 8'd0;
         index_ff       <= '0;
         total_ff       <= '0;
         length_high_ff <= 8'd0;
         take_ff        <= 1'b1;
         crc_ff         <= CRC_INIT;
         trailer_ff     <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            history_ff     <= history_in;
            phase_ff       <= phase_in;
            mode_ff        <= mode_in;
            bit_count_ff   <= bit_count_in;
            shift_ff       <= shift_in;
            index_ff       <= index_in;
            total_ff       <= total_in;
            length_high_ff <= length_high_in;
            take_ff        <= take_in;
            crc_ff         <= crc_in;
            trailer_ff     <= trailer_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_bit_ff    <= in_bit_in;
      out_data_ff  <= out_data_in;
      out_index_ff <= out_index_in;
      out_mode_ff  <= out_mode_in;
      out_last_ff  <= out_last_in;
      out_ok_ff    <= out_ok_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {16'(out_index_ff), out_data_ff};
   assign rsp_tuser  = {out_err_ff, out_ok_ff, out_mode_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// File: sv/dmsd_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsd_csr: configuration registers behind an APB-style port
// Five registers at 0, 8, 16, 24, 32 (paddr[5:3]); writes at 40 and up drop.
// ----------------------------------------------------------------------------
module dmsd_csr
   import dmsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   localparam logic [2:0] REG_SYNC_MODE1 = 3'd0;
   localparam logic [2:0] REG_SYNC_MODE2 = 3'd1;
   localparam logic [2:0] REG_KEY_MODE1  = 3'd2;
   localparam logic [2:0] REG_KEY_MODE2  = 3'd3;
   localparam logic [2:0] REG_MAX_FRAME  = 3'd4;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[5:3];
   assign write_en  = psel & penable & pwrite & pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_SYNC_MODE1: cfg_in.sync_word_mode1 = pwdata;
            REG_SYNC_MODE2: cfg_in.sync_word_mode2 = pwdata;
            REG_KEY_MODE1:  cfg_in.key_mode1 = pwdata[7:0];
            REG_KEY_MODE2:  cfg_in.key_mode2 = pwdata[7:0];
            REG_MAX_FRAME:  cfg_in.max_frame = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SYNC_MODE1: prdata = cfg_ff.sync_word_mode1;
         REG_SYNC_MODE2: prdata = cfg_ff.sync_word_mode2;
         REG_KEY_MODE1:  prdata = {56'd0, cfg_ff.key_mode1};
         REG_KEY_MODE2:  prdata = {56'd0, cfg_ff.key_mode2};
         REG_MAX_FRAME:  prdata = {48'd0, cfg_ff.max_frame};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word_mode1 <= 64'hAAAAAAAA55A59AA6;
         cfg_ff.sync_word_mode2 <= 64'hAAAAAAAA9A99A656;
         cfg_ff.key_mode1       <= 8'h55;
         cfg_ff.key_mode2       <= 8'hAA;
         cfg_ff.max_frame       <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/deframer_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_check_pkg: frame byte predictor and scoreboard
// Bit-level model of the sync search, byte assembly, length handling and
// CRC-16/X.25 trailer check, plus the queue of frame bytes still owed.
// ----------------------------------------------------------------------------
package deframer_check_pkg;
   import dmsd_pkg::*;

   typedef enum int {
      REG_SYNC_MODE1 = 0,
      REG_SYNC_MODE2 = 1,
      REG_KEY_MODE1  = 2,
      REG_KEY_MODE2  = 3,
      REG_MAX_FRAME  = 4
   } csr_index_type;

   typedef enum logic [1:0] {
      SEARCHING,
      IN_LENGTH,
      IN_BODY
   } frame_phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic        frame_mode;
      logic        last;
      logic        crc_ok;
      logic        frame_error;
   } frame_byte_type;

   class frame_byte_scoreboard;
      logic [63:0]     sync_word1;
      logic [63:0]     sync_word2;
      logic [7:0]      key1;
      logic [7:0]      key2;
      logic [15:0]     max_frame_len;

      logic [63:0]     history;
      frame_phase_type phase;
      logic            nrz;
      logic [2:0]      bit_cnt;
      logic [7:0]      shreg;
      logic [15:0]     index;
      int unsigned     total;
      logic [7:0]      len_high;
      logic            take;
      logic [15:0]     crc;
      logic [7:0]      trailer_low;

      frame_byte_type  expected_bytes[$];
      int              mismatch_count;

      function new();
         sync_word1     = 64'hAAAAAAAA55A59AA6;
         sync_word2     = 64'hAAAAAAAA9A99A656;
         key1           = 8'h55;
         key2           = 8'hAA;
         max_frame_len  = 16'hFFFF;
         history        = '0;
         phase          = SEARCHING;
         nrz            = 1'b0;
         bit_cnt        = '0;
         shreg          = '0;
         index          = '0;
         total          = 0;
         len_high       = '0;
         take           = 1'b1;
         crc            = CRC_INIT;
         trailer_low    = '0;
         mismatch_count = 0;
      endfunction

      // Reflected CRC update, one data bit at a time, least significant first.
      function logic [15:0] crc_x25_step(logic [15:0] c, logic [7:0] d);
         for (int i = 0; i < 8; i++) begin
            c = (c[0] ^ d[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void write_reg(csr_index_type which, logic [63:0] value);
         case (which)
            REG_SYNC_MODE1: sync_word1 = value;
            REG_SYNC_MODE2: sync_word2 = value;
            REG_KEY_MODE1:  key1 = value[7:0];
            REG_KEY_MODE2:  key2 = value[7:0];
            REG_MAX_FRAME:  max_frame_len = value[15:0];
            default: ;
         endcase
      endfunction

      function void owe_byte(logic [7:0] d, logic [15:0] at, logic fin, logic ok, logic err);
         expected_bytes.push_back('{d, at, nrz, fin, ok, err});
      endfunction

      // Advances the model by one accepted input word.
      function void note_bit_word(logic kind, logic bitv);
         logic        used;
         logic [7:0]  b;
         int unsigned idx;
         if (kind) begin
            if (phase == SEARCHING) return;
            owe_byte(8'h00, index, 1'b1, 1'b0, 1'b1);
            phase = SEARCHING;
            return;
         end
         if (phase == SEARCHING) begin
            history = {history[62:0], bitv};
            if (history == sync_word1 || history == sync_word2) begin
               nrz         = (history != sync_word1);
               phase       = IN_LENGTH;
               bit_cnt     = '0;
               shreg       = '0;
               index       = '0;
               total       = 0;
               len_high    = '0;
               take        = 1'b1;
               crc         = CRC_INIT;
               trailer_low = '0;
            end
            return;
         end
         // Manchester frames use only the first bit of each pair.
         used = take | nrz;
         take = ~take;
         if (!used) return;
         shreg = {shreg[6:0], bitv};
         if (bit_cnt != 3'd7) begin
            bit_cnt++;
            return;
         end
         bit_cnt = '0;
         b       = shreg ^ (nrz ? key2 : key1);
         shreg   = '0;
         idx     = index;
         if (phase == IN_LENGTH) begin
            if (nrz && idx == 0) begin
               len_high = b;
               crc      = crc_x25_step(crc, b);
               index    = 16'(idx + 1);
               owe_byte(b, 16'(idx), 1'b0, 1'b0, 1'b0);
               return;
            end
            total = nrz ? int'({len_high, b}) + 2 : int'(b) + 2;
            if (total > max_frame_len || total > (1 << INDEX_BITS) || (nrz && total < 3)) begin
               owe_byte(b, 16'(idx), 1'b1, 1'b0, 1'b1);
               phase = SEARCHING;
               return;
            end
            phase = IN_BODY;
         end
         if (idx + 2 < total) crc = crc_x25_step(crc, b);
         else if (idx + 2 == total) trailer_low = b;
         if (idx + 1 >= total) begin
            owe_byte(b, 16'(idx), 1'b1, ((crc ^ 16'hFFFF) == {b, trailer_low}), 1'b0);
            phase = SEARCHING;
            return;
         end
         index = 16'(idx + 1);
         owe_byte(b, 16'(idx), 1'b0, 1'b0, 1'b0);
      endfunction

      task report_mismatch(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      function string field_text(string field, int got, int want, int at);
         return $sformatf("byte at index %0d: %s is %0h, expected %0h", at, field, got, want);
      endfunction

      task check_frame_byte(frame_byte_type got);
         frame_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h at index %0d arrived with nothing expected",
                                      got.data_byte, got.byte_index));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.data_byte !== want.data_byte)
            report_mismatch(field_text("data_byte", got.data_byte, want.data_byte,
                                       want.byte_index));
         if (got.byte_index !== want.byte_index)
            report_mismatch(field_text("byte_index", got.byte_index, want.byte_index,
                                       want.byte_index));
         if (got.frame_mode !== want.frame_mode)
            report_mismatch(field_text("frame_mode", got.frame_mode, want.frame_mode,
                                       want.byte_index));
         if (got.last !== want.last)
            report_mismatch(field_text("last", got.last, want.last, want.byte_index));
         if (got.crc_ok !== want.crc_ok)
            report_mismatch(field_text("crc_ok", got.crc_ok, want.crc_ok, want.byte_index));
         if (got.frame_error !== want.frame_error)
            report_mismatch(field_text("frame_error", got.frame_error, want.frame_error,
                                       want.byte_index));
      endtask
   endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual-mode sync deframer
// Sends sync-framed Manchester and NRZ bit streams mixed with noise, aborts,
// bad lengths and corrupted trailers, and checks every frame byte against a
// bit-level predictor. Registers change between phases while the block is
// idle, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import dmsd_pkg::*;
   import deframer_check_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 7;
   // A word passes through the input register on its way to the result register,
   // so this pause is plenty to let any word that causes no result leave the pipeline.
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int TOTAL_WORDS   = 1850;
   localparam int PHASE_WORDS   = 200;
   localparam int STAGE_SWAP    = 600;
   localparam int STAGE_CALM    = 1200;
   localparam int PRESSURE_AT   = 1400;
   localparam int HOLD_CYCLES   = 400;

   localparam logic KIND_BIT   = 1'b0;
   localparam logic KIND_ABORT = 1'b1;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;   // [0] bit_value, rest zero
   logic                     req_tuser   = 1'b0; // [0] kind
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [23:0]              rsp_tdata;          // [7:0] data_byte, [23:8] byte_index
   logic [2:0]               rsp_tuser;          // [0] frame_mode, [1] crc_ok,
                                                 // [2] frame_error
   logic                     rsp_tlast;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   frame_byte_scoreboard sb;

   // Idling stage: 0 has a lazy receiver, 1 a lazy sender, 2 neither.
   logic [1:0] idle_stage = 2'd0;
   int         sender_idle_pct [3]   = '{22, 85, 0};
   int         receiver_idle_pct [3] = '{85, 22, 0};

   int   words_sent   = 0;
   int   cycle_count  = 0;
   int   hold_left    = 0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;

   dual_mode_sync_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // The run must end on its own; a hang anywhere lands here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Both handshakes are sampled at the rising edge, before the block's own
   // registers move, so the values seen are the ones the block acted on.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_frame_byte(frame_byte_type'{rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser[0],
                                                 rsp_tlast, rsp_tuser[1], rsp_tuser[2]});
         if (req_tvalid && req_tready)
            sb.note_bit_word(req_tuser, req_tdata[0]);
      end
   end

   // The idling stage and the long receiver hold follow the words sent so far.
   always @(posedge clock) begin
      idle_stage <= (words_sent < STAGE_SWAP) ? 2'd0 : (words_sent < STAGE_CALM) ? 2'd1 : 2'd2;
      if (words_sent >= PRESSURE_AT) hold_request <= 1'b1;
   end

   // The receiver stalls at the rate of the current stage. Once during the
   // run it holds off for a long stretch so that the block fills up and has
   // to push back on the sender.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct[idle_stage]);
      end
   end

   // Offers one word and returns at the edge where it is taken. Before that
   // the sender idles in each cycle at the rate of the current stage.
   task automatic send_word(input logic kind, input logic bitv);
      while ($urandom_range(99) < sender_idle_pct[idle_stage]) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, bitv};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Random channel bits with an occasional abort word mixed in.
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(7) == 0) send_word(KIND_ABORT, 1'($urandom_range(1)));
         else send_word(KIND_BIT, 1'($urandom_range(1)));
      end
   endtask

   // Sends the sync word of the chosen mode, then the scrambled frame bytes,
   // MSB first. Manchester frames follow each data bit with a filler bit the
   // block is meant to skip. A frame whose length the block must refuse is
   // cut after its length bytes. With abort_at at a byte position, an abort
   // word replaces a random bit of that byte.
   task automatic send_frame(input logic nrz, input int len_field, input logic spoil_crc,
                             input int abort_at);
      logic [7:0]  plain [$];
      logic [63:0] sync;
      logic [15:0] fcs;
      logic [7:0]  key;
      logic [7:0]  line_byte;
      int          total;
      int          head;
      int          n_send;
      int          abort_bit;
      int          pick;
      total  = len_field + 2;
      head   = nrz ? 2 : 1;
      n_send = (total > int'(sb.max_frame_len) || (nrz && total < 3)) ? head : total;
      for (int k = 0; k < n_send; k++) begin
         pick = $urandom_range(7);
         plain.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(255)));
      end
      if (nrz) begin
         plain[0] = len_field[15:8];
         plain[1] = len_field[7:0];
      end else begin
         plain[0] = len_field[7:0];
      end
      // The trailer goes out low byte first. In the shortest frames it
      // overlaps the length field, which then stays as it is.
      if (n_send == total) begin
         fcs = CRC_INIT;
         for (int k = 0; k < total - 2; k++) fcs = sb.crc_x25_step(fcs, plain[k]);
         fcs = ~fcs;
         if (spoil_crc) fcs = fcs ^ (16'h1 << $urandom_range(15));
         if (total - 2 >= head) plain[total - 2] = fcs[7:0];
         if (total - 1 >= head) plain[total - 1] = fcs[15:8];
      end
      sync      = nrz ? sb.sync_word2 : sb.sync_word1;
      key       = nrz ? sb.key2 : sb.key1;
      abort_bit = $urandom_range(7);
      for (int i = 63; i >= 0; i--) send_word(KIND_BIT, sync[i]);
      for (int k = 0; k < n_send; k++) begin
         line_byte = plain[k] ^ key;
         for (int i = 7; i >= 0; i--) begin
            if (k == abort_at && i == abort_bit) begin
               send_word(KIND_ABORT, 1'($urandom_range(1)));
               return;
            end
            send_word(KIND_BIT, line_byte[i]);
            if (!nrz) send_word(KIND_BIT, 1'($urandom_range(1)));
         end
      end
   endtask

   // Register write with a setup phase and an access phase; the register takes the data at the edge that
   // ends the access cycle.
   task automatic csr_write(input csr_index_type which, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(int'(which) * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(which, value);
   endtask

   // Stops offering words, waits for every owed byte, then lets any word
   // that causes no byte drain out of the block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int   next_config;
      int   pick;
      int   len;
      logic nrz;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed cases with the reset settings: aborts while searching,
      // good frames in both modes, a corrupted trailer, a mode 2 length too
      // short and one too long, aborts inside the body and inside the
      // two-byte length, and an empty Manchester frame.
      send_word(KIND_ABORT, 1'b0);
      send_word(KIND_ABORT, 1'b1);
      send_noise(6);
      send_frame(1'b0, 3, 1'b0, -1);
      send_frame(1'b1, 2, 1'b0, -1);
      send_frame(1'b0, 4, 1'b1, -1);
      send_frame(1'b1, 0, 1'b0, -1);
      send_frame(1'b1, 16'hFFFF, 1'b0, -1);
      send_frame(1'b0, 5, 1'b0, 2);
      send_frame(1'b0, 0, 1'b0, -1);
      send_frame(1'b1, 4, 1'b0, 0);

      // Both sync words equal, so mode 1 must win. The smallest frame limit
      // accepts a total of three bytes and refuses four.
      wait_idle();
      csr_write(REG_SYNC_MODE1, '1);
      csr_write(REG_SYNC_MODE2, '1);
      csr_write(REG_KEY_MODE1, 64'h00);
      csr_write(REG_KEY_MODE2, 64'hFF);
      csr_write(REG_MAX_FRAME, 64'd3);
      send_frame(1'b0, 1, 1'b0, -1);
      send_frame(1'b0, 2, 1'b0, -1);
      send_frame(1'b0, 0, 1'b1, -1);

      // An all-zero sync word, inverted keys and the largest frame limit,
      // which still refuses a 16-bit length just below the top.
      wait_idle();
      csr_write(REG_SYNC_MODE1, '0);
      csr_write(REG_SYNC_MODE2, {$urandom, $urandom});
      csr_write(REG_KEY_MODE1, 64'hFF);
      csr_write(REG_KEY_MODE2, 64'h00);
      csr_write(REG_MAX_FRAME, 64'hFFFF);
      send_frame(1'b1, 3, 1'b0, -1);
      send_frame(1'b1, 16'hFFFE, 1'b0, -1);
      send_frame(1'b0, 2, 1'b0, -1);

      // Random part: mostly well-formed frames with random content, the
      // rest broken frames and noise, until the word budget is spent.
      // Settings change every couple of hundred words.
      next_config = words_sent;
      while (words_sent < TOTAL_WORDS) begin
         if (words_sent >= next_config) begin
            wait_idle();
            csr_write(REG_SYNC_MODE1, {$urandom, $urandom});
            csr_write(REG_SYNC_MODE2, {$urandom, $urandom});
            csr_write(REG_KEY_MODE1, 64'($urandom_range(255)));
            csr_write(REG_KEY_MODE2, 64'($urandom_range(255)));
            csr_write(REG_MAX_FRAME,
                      ($urandom_range(2) == 0) ? 64'($urandom_range(40, 3)) : 64'hFFFF);
            next_config = words_sent + PHASE_WORDS;
         end
         nrz  = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(nrz, nrz ? $urandom_range(12, 1) : $urandom_range(8), 1'b0, -1);
         end else if (pick < 65) begin
            send_frame(nrz, nrz ? $urandom_range(12, 1) : $urandom_range(8), 1'b1, -1);
         end else if (pick < 73) begin
            len = $urandom_range(8, 1);
            send_frame(nrz, len, 1'b0, $urandom_range(len + 1));
         end else if (pick < 80) begin
            // A mode 2 length that is either too short or above the limit.
            len = ($urandom_range(1) == 0) ? 0
                  : $urandom_range(65535, int'(sb.max_frame_len) - 1);
            send_frame(1'b1, len, 1'b0, -1);
         end else if (pick < 92) begin
            send_noise($urandom_range(16, 1));
         end else begin
            send_frame(nrz, $urandom_range(30, 13), 1'b0, -1);
         end
      end

      wait_idle();
      if (sb.mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/dmsd_pkg.sv
sv/dmsd_csr.sv
sv/dual_mode_sync_deframer.sv
tb/sv/deframer_check_pkg.sv
tb/sv/testbench.sv
